FILE: rtl/dual_ntc_temperature_check_assert.svh
// ----------------------------------------------------------------------------
// dual_ntc_temperature_check_assert.svh
// Assertion macros shared by the thermistor check RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_NTC_TEMPERATURE_CHECK_ASSERT_SVH
`define DUAL_NTC_TEMPERATURE_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DNTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DNTC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dntc_pkg.sv
// ----------------------------------------------------------------------------
// dntc_pkg
// Types, constants and the thermistor ROM for the dual NTC check.
// ----------------------------------------------------------------------------
package dntc_pkg;

   localparam int SAMPLE_W        = 12;
   localparam int TEMP_W          = 8;
   localparam int ROM_W           = 16;
   localparam int ROM_SLOTS       = 128;
   localparam int ROM_IDX_W       = 7;
   localparam int CSR_IDX_W       = 1;
   localparam int BELOW_ZERO_SPAN = 20;

   localparam logic [TEMP_W-1:0] NO_SEGMENT    = 8'hFF;
   localparam logic [TEMP_W-1:0] MISMATCH_CODE = 8'hEE;
   localparam logic [TEMP_W-1:0] CAL_RESET     = 8'd4;
   localparam logic [TEMP_W-1:0] LIMIT_RESET   = 8'd5;

   // Register map of the write port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_OFFSET     = 1'b0,
      CSR_MISMATCH_LIMIT = 1'b1
   } csr_reg_type;

   // Top-level sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK_A,
      ST_LOOK_B,
      ST_OUT
   } seq_state_type;

   // Sequencer to lookup unit
   typedef struct packed {
      logic                start;
      logic [SAMPLE_W-1:0] sample;
   } lk_ctrl_type;

   // Lookup unit to sequencer
   typedef struct packed {
      logic              done;
      logic [TEMP_W-1:0] temp;
   } lk_stat_type;

   // Descending calibration points; unused slots read zero
   function automatic logic [ROM_W-1:0] ntc_rom(input logic [ROM_IDX_W-1:0] idx);
      logic [ROM_W-1:0] val;
      unique case (idx)
         7'd0:  val = 16'h7FFF;
         7'd1:  val = 16'd3605;
         7'd2:  val = 16'd3582;
         7'd3:  val = 16'd3557;
         7'd4:  val = 16'd3533;
         7'd5:  val = 16'd3507;
         7'd6:  val = 16'd3481;
         7'd7:  val = 16'd3454;
         7'd8:  val = 16'd3426;
         7'd9:  val = 16'd3397;
         7'd10: val = 16'd3368;
         7'd11: val = 16'd3338;
         7'd12: val = 16'd3307;
         7'd13: val = 16'd3276;
         7'd14: val = 16'd3243;
         7'd15: val = 16'd3211;
         7'd16: val = 16'd3177;
         7'd17: val = 16'd3143;
         7'd18: val = 16'd3108;
         7'd19: val = 16'd3073;
         7'd20: val = 16'd3037;
         7'd21: val = 16'd3001;
         7'd22: val = 16'd2964;
         7'd23: val = 16'd2927;
         7'd24: val = 16'd2889;
         7'd25: val = 16'd2850;
         7'd26: val = 16'd2812;
         7'd27: val = 16'd2773;
         7'd28: val = 16'd2733;
         7'd29: val = 16'd2694;
         7'd30: val = 16'd2654;
         7'd31: val = 16'd2614;
         7'd32: val = 16'd2573;
         7'd33: val = 16'd2533;
         7'd34: val = 16'd2492;
         7'd35: val = 16'd2452;
         7'd36: val = 16'd2411;
         7'd37: val = 16'd2370;
         7'd38: val = 16'd2329;
         7'd39: val = 16'd2289;
         7'd40: val = 16'd2248;
         7'd41: val = 16'd2208;
         7'd42: val = 16'd2167;
         7'd43: val = 16'd2127;
         7'd44: val = 16'd2087;
         7'd45: val = 16'd2048;
         7'd46: val = 16'd2008;
         7'd47: val = 16'd1969;
         7'd48: val = 16'd1930;
         7'd49: val = 16'd1892;
         7'd50: val = 16'd1854;
         7'd51: val = 16'd1816;
         7'd52: val = 16'd1778;
         7'd53: val = 16'd1742;
         7'd54: val = 16'd1705;
         7'd55: val = 16'd1669;
         7'd56: val = 16'd1634;
         7'd57: val = 16'd1598;
         7'd58: val = 16'd1564;
         7'd59: val = 16'd1530;
         7'd60: val = 16'd1496;
         7'd61: val = 16'd1463;
         7'd62: val = 16'd1431;
         7'd63: val = 16'd1399;
         7'd64: val = 16'd1368;
         7'd65: val = 16'd1337;
         7'd66: val = 16'd1306;
         7'd67: val = 16'd1277;
         7'd68: val = 16'd1247;
         7'd69: val = 16'd1219;
         7'd70: val = 16'd1191;
         7'd71: val = 16'd1163;
         7'd72: val = 16'd1136;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/dntc_req_if.sv
// ----------------------------------------------------------------------------
// dntc_req_if
// Sample pair channel: valid/ready handshake with both thermistor readings.
// ----------------------------------------------------------------------------
interface dntc_req_if import dntc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_first;
   logic [SAMPLE_W-1:0] sample_second;

   modport source (output valid, output sample_first, output sample_second, input ready);
   modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

FILE: rtl/dntc_rsp_if.sv
// ----------------------------------------------------------------------------
// dntc_rsp_if
// Result channel: valid/ready handshake with temperature and fault flag.
// ----------------------------------------------------------------------------
interface dntc_rsp_if import dntc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temperature;
   logic              sensor_mismatch;

   modport source (output valid, output temperature, output sensor_mismatch, input ready);
   modport sink   (input valid, input temperature, input sensor_mismatch, output ready);
endinterface

FILE: rtl/dntc_lookup.sv
// ----------------------------------------------------------------------------
// dntc_lookup
// Iterative ROM walker: one segment compare per cycle, shared by both samples.
// ----------------------------------------------------------------------------
`include "dual_ntc_temperature_check_assert.svh"

module dntc_lookup import dntc_pkg::*; #(
   parameter int TABLE_ENTRIES = 74
) (
   input  logic        clock,
   input  logic        reset,
   input  lk_ctrl_type ctrl,
   output lk_stat_type stat
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int LAST_K = TABLE_ENTRIES - 2;

   logic                busy_ff, busy_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                done_ff, done_in;
   logic [TEMP_W-1:0]   temp_ff, temp_in;

   logic [ROM_IDX_W-1:0] rom_idx;
   logic [ROM_W-1:0]     rom_hi, rom_lo;
   logic [ROM_W-1:0]     sample_ext;
   logic                 hit;
   logic                 last;
   logic [TEMP_W-1:0]    k_byte;
   logic [TEMP_W-1:0]    seg_temp;

   // Segment compare: rom[k] >= sample > rom[k+1]
   assign rom_idx    = ROM_IDX_W'(k_ff);
   assign rom_hi     = ntc_rom(rom_idx);
   assign rom_lo     = ntc_rom(rom_idx + ROM_IDX_W'(1));
   assign sample_ext = ROM_W'(sample_ff);
   assign hit        = (sample_ext <= rom_hi) && (sample_ext > rom_lo);
   assign last       = (k_ff == IDX_W'(LAST_K));

   // Below-zero segments map to zero
   assign k_byte   = TEMP_W'(k_ff);
   assign seg_temp = (k_byte >= TEMP_W'(BELOW_ZERO_SPAN))
                   ? k_byte - TEMP_W'(BELOW_ZERO_SPAN) : '0;

   // Walk control
   always_comb begin
      busy_in   = busy_ff;
      k_in      = k_ff;
      sample_in = sample_ff;
      done_in   = 1'b0;
      temp_in   = temp_ff;
      if (ctrl.start) begin
         busy_in   = 1'b1;
         k_in      = '0;
         sample_in = ctrl.sample;
      end else if (busy_ff) begin
         if (hit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            temp_in = seg_temp;
         end else if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            temp_in = NO_SEGMENT;
         end else begin
            k_in = k_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      sample_ff <= sample_in;
      temp_ff   <= temp_in;
   end

   assign stat.done = done_ff;
   assign stat.temp = temp_ff;

   // Checks
   `DNTC_ASSERT_IMP(a_k_in_range, clock, reset, busy_ff, k_ff <= IDX_W'(LAST_K), "walk index past end")
   `DNTC_ASSERT_IMP(a_start_when_free, clock, reset, ctrl.start, !busy_ff, "start while busy")
   `DNTC_ASSERT_NXT(a_done_pulse, clock, reset, done_ff, !done_ff, "done not a pulse")

endmodule

FILE: rtl/dntc_combine.sv
// ----------------------------------------------------------------------------
// dntc_combine
// Calibrates both bytes, checks agreement and averages them if they agree.
// ----------------------------------------------------------------------------
module dntc_combine import dntc_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  logic [TEMP_W-1:0] raw_a,
   input  logic [TEMP_W-1:0] raw_b,
   input  logic [TEMP_W-1:0] cal_offset,
   input  logic [TEMP_W-1:0] limit,
   output logic [TEMP_W-1:0] temperature,
   output logic              mismatch
);

   logic [TEMP_W-1:0] ta, tb, diff;
   logic [TEMP_W:0]   sum;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic              mismatch_ff, mismatch_in;

   // Offset wraps modulo 256
   assign ta   = raw_a - cal_offset;
   assign tb   = raw_b - cal_offset;
   assign diff = (ta < tb) ? tb - ta : ta - tb;
   assign sum  = {1'b0, ta} + {1'b0, tb};

   always_comb begin
      temp_in     = temp_ff;
      mismatch_in = mismatch_ff;
      if (load) begin
         if (diff > limit) begin
            temp_in     = MISMATCH_CODE;
            mismatch_in = 1'b1;
         end else begin
            temp_in     = sum[TEMP_W:1];
            mismatch_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      temp_ff     <= temp_in;
      mismatch_ff <= mismatch_in;
   end

   assign temperature = temp_ff;
   assign mismatch    = mismatch_ff;

endmodule

FILE: rtl/dual_ntc_temperature_check.sv
// ----------------------------------------------------------------------------
// dual_ntc_temperature_check
// Converts two NTC samples to temperature bytes and cross-checks them.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req_if  | in  | valid/ready        | sample_first, sample_second
//  rsp_if  | out | valid/ready        | temperature, sensor_mismatch
//  csr_*   | in  | csr_wr_en          | csr_index, csr_wdata
//
//  One transaction at a time; ready is low from acceptance until the result
//  is taken. Each sample walks the ROM one segment per cycle in the shared
//  lookup unit, with up to TABLE_ENTRIES-1 compares each; the combine
//  register then loads the calibrated result.
//  Reset is synchronous and restores offset 4 and limit 5.
//  A stalled result holds in its register until rsp_if.ready.
// ----------------------------------------------------------------------------
`include "dual_ntc_temperature_check_assert.svh"

module dual_ntc_temperature_check import dntc_pkg::*; #(
   parameter int TABLE_ENTRIES = 74
) (
   input  logic                 clock,
   input  logic                 reset,
   dntc_req_if.sink             req_if,
   dntc_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TEMP_W-1:0]    csr_wdata
);

   seq_state_type state_ff, state_in;

   logic [TEMP_W-1:0]   cal_ff, cal_in;
   logic [TEMP_W-1:0]   limit_ff, limit_in;
   logic [SAMPLE_W-1:0] sample_b_ff, sample_b_in;
   logic [TEMP_W-1:0]   raw_a_ff, raw_a_in;

   lk_ctrl_type lk_ctrl;
   lk_stat_type lk_stat;
   logic        req_fire;
   logic        rsp_fire;
   logic        comb_load;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   // Configuration registers
   always_comb begin
      cal_in   = cal_ff;
      limit_in = limit_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            CSR_CAL_OFFSET:     cal_in   = csr_wdata;
            CSR_MISMATCH_LIMIT: limit_in = csr_wdata;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_LOOK_A;
         ST_LOOK_A: if (lk_stat.done) state_in = ST_LOOK_B;
         ST_LOOK_B: if (lk_stat.done) state_in = ST_OUT;
         ST_OUT:    if (rsp_fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath steering
   always_comb begin
      req_if.ready   = 1'b0;
      rsp_if.valid   = 1'b0;
      lk_ctrl.start  = 1'b0;
      lk_ctrl.sample = req_if.sample_first;
      comb_load      = 1'b0;
      sample_b_in    = sample_b_ff;
      raw_a_in       = raw_a_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready  = 1'b1;
            lk_ctrl.start = req_if.valid;
            sample_b_in   = req_if.sample_second;
         end
         ST_LOOK_A: begin
            lk_ctrl.start  = lk_stat.done;
            lk_ctrl.sample = sample_b_ff;
            if (lk_stat.done) raw_a_in = lk_stat.temp;
         end
         ST_LOOK_B: begin
            comb_load = lk_stat.done;
         end
         ST_OUT: begin
            rsp_if.valid = 1'b1;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cal_ff   <= CAL_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         cal_ff   <= cal_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_b_ff <= sample_b_in;
      raw_a_ff    <= raw_a_in;
   end

   // Shared segment walker
   dntc_lookup #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_lookup (
      .clock (clock),
      .reset (reset),
      .ctrl  (lk_ctrl),
      .stat  (lk_stat)
   );

   // Calibration, agreement check and average
   dntc_combine u_combine (
      .clock       (clock),
      .load        (comb_load),
      .raw_a       (raw_a_ff),
      .raw_b       (lk_stat.temp),
      .cal_offset  (cal_ff),
      .limit       (limit_ff),
      .temperature (rsp_if.temperature),
      .mismatch    (rsp_if.sensor_mismatch)
   );

   // Checks
   `DNTC_ASSERT_IMP(a_one_side, clock, reset, rsp_if.valid, !req_if.ready, "ready while result pending")
   `DNTC_ASSERT_IMP(a_done_in_walk, clock, reset, lk_stat.done, state_ff == ST_LOOK_A || state_ff == ST_LOOK_B, "lookup done outside walk")
   `DNTC_ASSERT_NXT(a_accept_walks, clock, reset, req_fire, state_ff == ST_LOOK_A, "accept did not start walk")
   `DNTC_ASSERT_IMP(a_fault_code, clock, reset, rsp_if.valid && rsp_if.sensor_mismatch, rsp_if.temperature == MISMATCH_CODE, "fault without fault code")

endmodule
